// ===== design/ccls_pkg.sv =====
// Shared types and constants of the C comment line stripper.
// Depends on nothing; the core, the controller and the datapath import it.
`timescale 1ns / 1ps

package ccls_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEEP2,
    ST_CLOSE,
    ST_LOAD,
    ST_SEND
  } ccls_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // input beat accepted this cycle
    logic keep2;    // store the held second byte
    logic close;    // end the chunk
    logic load;     // read the first buffered byte
    logic advance;  // output beat taken, read the next byte
    logic clear;    // end of text done, return to reset state
  } ccls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_keep2;  // current input needs a second buffer write
    logic chunk_end;   // current input ends a chunk
    logic eot_in;      // current input carries end of text
    logic end_pend;    // accepted input ends a chunk
    logic last_pend;   // accepted input carried end of text
    logic emit;        // chunk being closed is non-blank
    logic last_char;   // read pointer is on the last kept byte
  } ccls_status_t;

endpackage

// ===== design/ccls_ifs.sv =====
// Stream interfaces of the comment stripper: text bytes in, line characters out.
// Standalone; used by the top level and by the environment around it.
`timescale 1ns / 1ps

interface ccls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface ccls_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [15:0] line_number;
  logic [15:0] stored_index;
  logic [5:0]  char_position;
  logic        last_of_line;

  modport source (output valid, output byte_out, output line_number, output stored_index,
                  output char_position, output last_of_line, input ready);
  modport sink   (input valid, input byte_out, input line_number, input stored_index,
                  input char_position, input last_of_line, output ready);
endinterface

// ===== design/c_comment_line_stripper_core.sv =====
// C comment line stripper: takes source text a byte per beat, drops // and
// block comments, and sends each non-blank line as a run of character beats
// tagged with its source line number, its ordinal among sent lines and the
// character position. A byte that ends no chunk is taken in ST_IDLE; a byte
// that keeps a stray slash plus itself needs a second buffer write in ST_KEEP2,
// because the line buffer RAM has a single write port. A chunk end (newline,
// LINE_CHARS-1 raw bytes, or end of text) then passes through ST_CLOSE, and a
// sent line through ST_LOAD (RAM read), then ST_SEND while the sink is ready.
// No input is taken during readout. The line buffer needs no clearing pass.
// Depends on ccls_pkg, ccls_ifs, ccls_ctrl, ccls_datapath and ccls_ram.
`timescale 1ns / 1ps

module c_comment_line_stripper_core import ccls_pkg::*; #(
  parameter int LINE_CHARS = 64,
  parameter int COUNT_BITS = 16
) (
  input logic            clk,
  input logic            rst,
  ccls_in_if.sink        text,
  ccls_out_if.source     lines
);

  ccls_cmd_t    cmd;
  ccls_status_t status;

  ccls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text.valid),
    .out_ready (lines.ready),
    .status    (status),
    .in_ready  (text.ready),
    .out_valid (lines.valid),
    .cmd       (cmd)
  );

  ccls_datapath #(
    .LINE_CHARS (LINE_CHARS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .byte_in       (text.byte_in),
    .end_of_text   (text.end_of_text),
    .cmd           (cmd),
    .status        (status),
    .byte_out      (lines.byte_out),
    .line_number   (lines.line_number),
    .stored_index  (lines.stored_index),
    .char_position (lines.char_position),
    .last_of_line  (lines.last_of_line)
  );

  // Input is never taken while a line is being read out.
  assert property (@(posedge clk) disable iff (rst) lines.valid |-> !text.ready)
    else $error("input ready during line readout");

  // The last character of a line ends the readout.
  assert property (@(posedge clk) disable iff (rst)
    lines.valid && lines.ready && lines.last_of_line |=> !lines.valid)
    else $error("output continues after last character of a line");

  // Within a line, positions step by one and the line number stays put.
  assert property (@(posedge clk) disable iff (rst)
    lines.valid && lines.ready && !lines.last_of_line |=>
      lines.valid && lines.char_position == 6'($past(lines.char_position) + 6'd1)
      && lines.line_number == $past(lines.line_number))
    else $error("character position or line tag broken inside a line");

endmodule

// ===== design/ccls_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ccls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ccls_ctrl.sv =====
// Controller state machine of the comment stripper: sequences byte intake,
// second buffer writes, chunk close and line readout. Uses ccls_pkg.
`timescale 1ns / 1ps

module ccls_ctrl import ccls_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         out_ready,
  input  ccls_status_t status,
  output logic         in_ready,
  output logic         out_valid,
  output ccls_cmd_t    cmd
);

  ccls_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.need_keep2) begin
            state_next = ST_KEEP2;
          end else if (status.chunk_end) begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_KEEP2: state_next = status.end_pend ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: state_next = status.emit ? ST_LOAD : ST_IDLE;
      ST_LOAD:  state_next = ST_SEND;
      ST_SEND: begin
        if (out_ready && status.last_char) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        // End of text on a beat that closes no chunk resets right away.
        cmd.clear = in_valid && status.eot_in && !status.chunk_end
                    && !status.need_keep2;
      end
      ST_KEEP2: begin
        cmd.keep2 = 1'b1;
        cmd.clear = status.last_pend && !status.end_pend;
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        cmd.clear = status.last_pend && !status.emit;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_SEND: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !status.last_char;
        cmd.clear   = out_ready && status.last_char && status.last_pend;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/ccls_datapath.sv =====
// Datapath of the comment stripper: comment scanner flags, chunk counters,
// line buffer RAM and the readout pointer. Uses ccls_pkg and ccls_ram.
`timescale 1ns / 1ps

module ccls_datapath import ccls_pkg::*; #(
  parameter int LINE_CHARS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   byte_in,
  input  logic         end_of_text,
  input  ccls_cmd_t    cmd,
  output ccls_status_t status,
  output logic [7:0]   byte_out,
  output logic [15:0]  line_number,
  output logic [15:0]  stored_index,
  output logic [5:0]   char_position,
  output logic         last_of_line
);

  localparam int DEPTH = LINE_CHARS - 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(LINE_CHARS);
  localparam logic [CW-1:0]         KEPT_MAX  = CW'(LINE_CHARS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  in_block_comment, slash_pending, star_pending, skip_rest_of_chunk;
  logic [CW-1:0]         kept_count, raw_count;
  logic                  seen_nonblank;
  logic [COUNT_BITS-1:0] line_counter, stored_counter;
  logic [7:0]            second_byte;
  logic                  end_pend, last_pend;
  logic [15:0]           emit_line, emit_stored;
  logic [CW-1:0]         emit_len;
  logic [AW-1:0]         rd_idx;

  // Scanner outcome for the byte on the input.
  logic          nz;
  logic [CW-1:0] raw_next;
  logic          chunk_end;
  logic          t_inblk, t_star, t_slash, t_skip;
  logic          t_keep1, t_keep2;
  logic [7:0]    t_kb;

  logic          keep_en, room, ram_we, ram_re;
  logic [7:0]    keep_val;
  logic [CW-1:0] kept_after;
  logic          nonblank_after;
  logic [COUNT_BITS-1:0] line_next;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  always_comb begin
    nz        = byte_in != CHAR_NUL;
    raw_next  = nz ? raw_count + CW'(1) : raw_count;
    chunk_end = (nz && (byte_in == CHAR_NL || raw_next >= KEPT_MAX))
             || (end_of_text && raw_next != '0);
    t_inblk = in_block_comment;
    t_star  = star_pending;
    t_slash = slash_pending;
    t_skip  = skip_rest_of_chunk;
    t_keep1 = 1'b0;
    t_keep2 = 1'b0;
    t_kb    = byte_in;
    if (nz && !skip_rest_of_chunk) begin
      if (in_block_comment) begin
        if (star_pending && byte_in == CHAR_SLASH) begin
          t_inblk = 1'b0;
          t_star  = 1'b0;
        end else begin
          t_star = byte_in == CHAR_STAR;
        end
      end else if (slash_pending) begin
        t_slash = 1'b0;
        if (byte_in == CHAR_SLASH) begin
          t_skip = 1'b1;
        end else if (byte_in == CHAR_STAR) begin
          t_inblk = 1'b1;
          t_star  = 1'b0;
        end else begin
          // A slash that opened nothing is kept, then the byte itself.
          t_keep1 = 1'b1;
          t_kb    = CHAR_SLASH;
          t_keep2 = 1'b1;
        end
      end else if (byte_in == CHAR_SLASH) begin
        t_slash = 1'b1;
      end else begin
        t_keep1 = 1'b1;
      end
    end
  end

  // One buffer write per cycle at most.
  always_comb begin
    keep_en  = 1'b0;
    keep_val = byte_in;
    if (cmd.take && t_keep1) begin
      keep_en  = 1'b1;
      keep_val = t_kb;
    end else if (cmd.keep2) begin
      keep_en  = 1'b1;
      keep_val = second_byte;
    end else if (cmd.close && slash_pending) begin
      keep_en  = 1'b1;
      keep_val = CHAR_SLASH;
    end
    room           = kept_count < KEPT_MAX;
    ram_we         = keep_en && room;
    kept_after     = ram_we ? kept_count + CW'(1) : kept_count;
    nonblank_after = seen_nonblank || (keep_en && keep_val != CHAR_SPACE
                     && keep_val != CHAR_TAB && keep_val != CHAR_NL);
    line_next      = (line_counter == COUNT_MAX) ? line_counter : line_counter + 1'b1;
    ram_re         = cmd.load || cmd.advance;
    raddr          = cmd.load ? '0 : rd_idx + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      in_block_comment   <= 1'b0;
      slash_pending      <= 1'b0;
      star_pending       <= 1'b0;
      skip_rest_of_chunk <= 1'b0;
      kept_count         <= '0;
      raw_count          <= '0;
      seen_nonblank      <= 1'b0;
      line_counter       <= '0;
      stored_counter     <= '0;
      end_pend           <= 1'b0;
      last_pend          <= 1'b0;
    end else begin
      if (cmd.take) begin
        in_block_comment   <= t_inblk;
        slash_pending      <= t_slash;
        star_pending       <= t_star;
        skip_rest_of_chunk <= t_skip;
        raw_count          <= raw_next;
        end_pend           <= chunk_end;
        last_pend          <= end_of_text;
      end
      kept_count    <= kept_after;
      seen_nonblank <= nonblank_after;
      if (cmd.close) begin
        slash_pending      <= 1'b0;
        star_pending       <= 1'b0;
        skip_rest_of_chunk <= 1'b0;
        line_counter       <= line_next;
        if (nonblank_after && stored_counter != COUNT_MAX) begin
          stored_counter <= stored_counter + 1'b1;
        end
        kept_count    <= '0;
        raw_count     <= '0;
        seen_nonblank <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      second_byte <= byte_in;
    end
    if (cmd.close) begin
      emit_line   <= 16'(32'(line_next));
      emit_stored <= 16'(32'(stored_counter));
      emit_len    <= kept_after;
    end
    if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.advance) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  ccls_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (kept_count[AW-1:0]),
    .wdata (keep_val),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A slash still pending at the close is kept as text, so it makes the line
  // non-blank.
  always_comb begin
    status.need_keep2 = t_keep2;
    status.chunk_end  = chunk_end;
    status.eot_in     = end_of_text;
    status.end_pend   = end_pend;
    status.last_pend  = last_pend;
    status.emit       = seen_nonblank || slash_pending;
    status.last_char  = (CW'(rd_idx) + CW'(1)) == emit_len;
    byte_out      = rdata;
    line_number   = emit_line;
    stored_index  = emit_stored;
    char_position = 6'(rd_idx);
    last_of_line  = status.last_char;
  end

endmodule
